/* src/tpg_pkg.sv */
// ---------------------------------------------------------------------------
// tpg_pkg
// Shared types and constants of the trapezoid pulse generator.
// ---------------------------------------------------------------------------
package tpg_pkg;

    localparam logic [31:0] START_DELAY = 32'd0;

    localparam int TICK_W  = 32;
    localparam int LEVEL_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // one remainder bit per stage over the 33-bit phase dividend
    localparam int MOD_BITS = TICK_W + 1;
    // ramp quotient never exceeds the 16-bit level span magnitude
    localparam int DIV_BITS = 16;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_LOW  = 3'd0,
        REG_LEVEL_HIGH = 3'd1,
        REG_RISE_TICKS = 3'd2,
        REG_HIGH_TICKS = 3'd3,
        REG_FALL_TICKS = 3'd4,
        REG_PERIOD     = 3'd5,
        REG_CLAMP_MIN  = 3'd6,
        REG_CLAMP_MAX  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_HIGH,
        SEG_RISE,
        SEG_FALL
    } t_seg;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level_low;
        logic signed [LEVEL_W-1:0] level_high;
        logic [TICK_W-1:0]         rise_ticks;
        logic [TICK_W-1:0]         high_ticks;
        logic [TICK_W-1:0]         fall_ticks;
        logic [TICK_W-1:0]         period_ticks;
        logic signed [LEVEL_W-1:0] clamp_min;
        logic signed [LEVEL_W-1:0] clamp_max;
    } t_cfg;

    // classified word passed from front to back
    typedef struct packed {
        t_seg                      seg;
        logic [TICK_W-1:0]         factor;
        logic signed [LEVEL_W-1:0] noise;
    } t_item;

endpackage

/* src/tpg_if.sv */
// ---------------------------------------------------------------------------
// tpg channel interfaces
// Input, output and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tpg_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [tpg_pkg::TICK_W-1:0]             tick_number;
    logic signed [tpg_pkg::LEVEL_W-1:0]     noise_sample;
    modport source (output valid, tick_number, noise_sample, input ready);
    modport sink   (input valid, tick_number, noise_sample, output ready);
endinterface

interface tpg_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tpg_pkg::LEVEL_W-1:0]     wave_sample;
    modport source (output valid, wave_sample, input ready);
    modport sink   (input valid, wave_sample, output ready);
endinterface

interface tpg_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [tpg_pkg::CFG_IDX_W-1:0]          index;
    logic [tpg_pkg::CFG_DATA_W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/tpg_front.sv */
// ---------------------------------------------------------------------------
// tpg_front
// Phase remainder pipeline (one bit per stage) and segment classification.
// ---------------------------------------------------------------------------
module tpg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpg_in_if.sink            i_in,
    input  tpg_pkg::t_cfg     i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output tpg_pkg::t_item    o_item
);

    localparam int LAST = tpg_pkg::MOD_BITS - 1;

    function automatic logic [31:0] mod_step(input logic [31:0] rem, input logic b,
                                             input logic [31:0] per);
        logic [32:0] t;
        t = {rem, b};
        if (t >= {1'b0, per}) begin
            t = t - {1'b0, per};
        end
        return t[31:0];
    endfunction

    logic [31:0]                 w_per;
    logic signed [33:0]          w_diff;
    logic [32:0]                 w_mag;
    logic                        w_adv;

    logic [31:0]                 r_rem   [tpg_pkg::MOD_BITS];
    logic [32:0]                 r_num   [tpg_pkg::MOD_BITS];
    logic signed [15:0]          r_noise [tpg_pkg::MOD_BITS];
    logic                        r_neg   [tpg_pkg::MOD_BITS];
    logic [tpg_pkg::MOD_BITS-1:0] r_vld;

    assign w_per  = (i_cfg.period_ticks == 32'd0) ? 32'd1 : i_cfg.period_ticks;
    assign w_diff = $signed({2'b00, i_in.tick_number}) + 34'sd1
                  - $signed({2'b00, tpg_pkg::START_DELAY});
    assign w_mag  = w_diff[33] ? 33'(-w_diff) : w_diff[32:0];

    assign w_adv      = !r_vld[LAST] || !i_full;
    assign i_in.ready = w_adv;
    assign o_push     = r_vld[LAST] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAST-1:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem[0]   <= mod_step(32'd0, w_mag[32], w_per);
            r_num[0]   <= {w_mag[31:0], 1'b0};
            r_noise[0] <= i_in.noise_sample;
            r_neg[0]   <= w_diff[33];
            for (int j = 1; j < tpg_pkg::MOD_BITS; j++) begin
                r_rem[j]   <= mod_step(r_rem[j-1], r_num[j-1][32], w_per);
                r_num[j]   <= {r_num[j-1][31:0], 1'b0};
                r_noise[j] <= r_noise[j-1];
                r_neg[j]   <= r_neg[j-1];
            end
        end
    end

    // segment of the phase within the period
    logic [31:0] w_p;
    logic [32:0] w_flat_end;
    logic [33:0] w_fall_end;

    always_comb begin
        w_p        = r_rem[LAST];
        w_flat_end = {1'b0, i_cfg.rise_ticks} + {1'b0, i_cfg.high_ticks};
        w_fall_end = {1'b0, w_flat_end} + {2'b00, i_cfg.fall_ticks};
        o_item.noise  = r_noise[LAST];
        o_item.factor = w_p;
        if (r_neg[LAST] && w_p != 32'd0) begin
            o_item.seg = tpg_pkg::SEG_LOW;
        end else if (w_p <= i_cfg.rise_ticks) begin
            o_item.seg = (i_cfg.rise_ticks == 32'd0) ? tpg_pkg::SEG_HIGH : tpg_pkg::SEG_RISE;
        end else if ({1'b0, w_p} < w_flat_end) begin
            o_item.seg = tpg_pkg::SEG_HIGH;
        end else if ({2'b00, w_p} < w_fall_end) begin
            o_item.seg    = tpg_pkg::SEG_FALL;
            o_item.factor = w_p - w_flat_end[31:0];
        end else begin
            o_item.seg = tpg_pkg::SEG_LOW;
        end
    end

endmodule

/* src/tpg_queue.sv */
// ---------------------------------------------------------------------------
// tpg_queue
// Short FIFO of classified words between front and back.
// ---------------------------------------------------------------------------
module tpg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpg_pkg::t_item    i_item,
    input  logic              i_pop,
    output tpg_pkg::t_item    o_item,
    output logic              o_full,
    output logic              o_empty
);

    typedef logic [tpg_pkg::QAW-1:0] QAW_T;

    tpg_pkg::t_item      r_mem [tpg_pkg::QDEPTH];
    logic [tpg_pkg::QAW-1:0] r_wp;
    logic [tpg_pkg::QAW-1:0] r_rp;
    logic [tpg_pkg::QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (tpg_pkg::QAW+1)'(tpg_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (tpg_pkg::QAW+1)'(tpg_pkg::QDEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count not incremented on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp == QAW_T'(r_rp + r_cnt[tpg_pkg::QAW-1:0]))
        else $error("queue pointers disagree with count");

endmodule

/* src/tpg_back.sv */
// ---------------------------------------------------------------------------
// tpg_back
// Ramp multiply, pipelined divide, noise add, clamp and output register.
// ---------------------------------------------------------------------------
module tpg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpg_pkg::t_cfg     i_cfg,
    input  tpg_pkg::t_item    i_item,
    input  logic              i_empty,
    output logic              o_pop,
    tpg_out_if.source         o_out
);

    localparam int ND   = tpg_pkg::DIV_BITS;
    localparam int LAST = ND - 1;

    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic b,
                                             input logic [31:0] dv);
        logic [32:0] t;
        logic        q;
        t = {rem, b};
        q = (t >= {1'b0, dv});
        if (q) begin
            t = t - {1'b0, dv};
        end
        return {q, t[31:0]};
    endfunction

    logic                w_adv;
    logic signed [16:0]  w_span;
    logic [15:0]         w_smag;

    // multiply stage
    logic                r_m_vld;
    logic [47:0]         r_m_prod;
    logic                r_m_neg;
    tpg_pkg::t_seg       r_m_seg;
    logic signed [15:0]  r_m_noise;

    // divide stages
    logic [ND-1:0]       r_d_vld;
    logic [31:0]         r_d_rem   [ND];
    logic [15:0]         r_d_low   [ND];
    logic [15:0]         r_d_q     [ND];
    logic                r_d_neg   [ND];
    tpg_pkg::t_seg       r_d_seg   [ND];
    logic signed [15:0]  r_d_noise [ND];

    logic                r_out_vld;
    logic signed [15:0]  r_wave;

    assign w_adv  = !r_out_vld || o_out.ready;
    assign o_pop  = w_adv && !i_empty;
    assign w_span = {i_cfg.level_high[15], i_cfg.level_high}
                  - {i_cfg.level_low[15], i_cfg.level_low};
    assign w_smag = w_span[16] ? 16'(-w_span) : w_span[15:0];

    function automatic logic [31:0] divisor(input tpg_pkg::t_seg s, input tpg_pkg::t_cfg c);
        return (s == tpg_pkg::SEG_FALL) ? c.fall_ticks : c.rise_ticks;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_d_vld   <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_m_vld   <= !i_empty;
            r_d_vld   <= {r_d_vld[LAST-1:0], r_m_vld};
            r_out_vld <= r_d_vld[LAST];
        end
    end

    // quotient bit and partial remainder of each divide stage
    logic [32:0] w_ds [ND];

    always_comb begin
        w_ds[0] = div_step(r_m_prod[47:16], r_m_prod[15], divisor(r_m_seg, i_cfg));
        for (int j = 1; j < ND; j++) begin
            w_ds[j] = div_step(r_d_rem[j-1], r_d_low[j-1][15],
                               divisor(r_d_seg[j-1], i_cfg));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_prod  <= 48'(w_smag) * 48'(i_item.factor);
            r_m_neg   <= w_span[16];
            r_m_seg   <= i_item.seg;
            r_m_noise <= i_item.noise;

            r_d_rem[0]   <= w_ds[0][31:0];
            r_d_q[0]     <= {15'd0, w_ds[0][32]};
            r_d_low[0]   <= {r_m_prod[14:0], 1'b0};
            r_d_neg[0]   <= r_m_neg;
            r_d_seg[0]   <= r_m_seg;
            r_d_noise[0] <= r_m_noise;
            for (int j = 1; j < ND; j++) begin
                r_d_rem[j]   <= w_ds[j][31:0];
                r_d_q[j]     <= {r_d_q[j-1][14:0], w_ds[j][32]};
                r_d_low[j]   <= {r_d_low[j-1][14:0], 1'b0};
                r_d_neg[j]   <= r_d_neg[j-1];
                r_d_seg[j]   <= r_d_seg[j-1];
                r_d_noise[j] <= r_d_noise[j-1];
            end
        end
    end

    // level, noise and saturation
    logic signed [17:0] w_sq;
    logic signed [17:0] w_level;
    logic signed [17:0] w_sum;
    logic signed [15:0] w_wave;

    always_comb begin
        w_sq = r_d_neg[LAST] ? -$signed({2'b00, r_d_q[LAST]}) : $signed({2'b00, r_d_q[LAST]});
        case (r_d_seg[LAST])
            tpg_pkg::SEG_RISE: w_level = 18'(i_cfg.level_low) + w_sq;
            tpg_pkg::SEG_FALL: w_level = 18'(i_cfg.level_high) - w_sq;
            tpg_pkg::SEG_HIGH: w_level = 18'(i_cfg.level_high);
            default:           w_level = 18'(i_cfg.level_low);
        endcase
        w_sum = w_level + 18'(r_d_noise[LAST]);
        if (w_sum > 18'(i_cfg.clamp_max)) begin
            w_wave = i_cfg.clamp_max;
        end else if (w_sum < 18'(i_cfg.clamp_min)) begin
            w_wave = i_cfg.clamp_min;
        end else begin
            w_wave = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wave <= w_wave;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.wave_sample = r_wave;

endmodule

/* src/trapezoid_pulse_generator.sv */
// Throughput: one word per cycle while the output is not stalled, set by the bit-per-stage remainder pipeline
// in the front and the bit-per-stage ramp divider in the back.
// A 4-word queue between front and back absorbs stalls of either side.
// Reset (synchronous, active low) clears all valid bits and queue pointers and
// loads the register defaults; configuration is always ready.
// ---------------------------------------------------------------------------
// trapezoid_pulse_generator
// Periodic trapezoidal pulse with additive noise and output saturation.
// ---------------------------------------------------------------------------
module trapezoid_pulse_generator (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tpg_in_if.sink     i_in,
    tpg_cfg_if.sink    i_cfg,
    tpg_out_if.source  o_out
);

    tpg_pkg::t_cfg  r_cfg;
    tpg_pkg::t_item w_f_item;
    tpg_pkg::t_item w_q_item;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_low    <= 16'sd0;
            r_cfg.level_high   <= 16'sd16384;
            r_cfg.rise_ticks   <= 32'd1;
            r_cfg.high_ticks   <= 32'd10;
            r_cfg.fall_ticks   <= 32'd1;
            r_cfg.period_ticks <= 32'd100;
            r_cfg.clamp_min    <= 16'h8000;
            r_cfg.clamp_max    <= 16'h7FFF;
        end else if (i_cfg.valid) begin
            case (tpg_pkg::t_reg_idx'(i_cfg.index))
                tpg_pkg::REG_LEVEL_LOW:  r_cfg.level_low    <= i_cfg.data[15:0];
                tpg_pkg::REG_LEVEL_HIGH: r_cfg.level_high   <= i_cfg.data[15:0];
                tpg_pkg::REG_RISE_TICKS: r_cfg.rise_ticks   <= i_cfg.data;
                tpg_pkg::REG_HIGH_TICKS: r_cfg.high_ticks   <= i_cfg.data;
                tpg_pkg::REG_FALL_TICKS: r_cfg.fall_ticks   <= i_cfg.data;
                tpg_pkg::REG_PERIOD:     r_cfg.period_ticks <= i_cfg.data;
                tpg_pkg::REG_CLAMP_MIN:  r_cfg.clamp_min    <= i_cfg.data[15:0];
                tpg_pkg::REG_CLAMP_MAX:  r_cfg.clamp_max    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    tpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_f_item)
    );

    tpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tpg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (w_q_item),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
